/* hdl/apq_pkg.sv */
// Shared types and constants for the array priority queue.
package apq_pkg;

   // Storage geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Field widths
   localparam int CMD_W = 2;
   localparam int VAL_W = 32;
   localparam int PRI_W = 16;

   // Command codes
   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_PUSH_SORTED = 2'd0;
   localparam cmd_type CMD_PUSH_APPEND = 2'd1;
   localparam cmd_type CMD_POP         = 2'd2;

   // One stored entry
   typedef struct packed {
      logic signed [VAL_W-1:0] val;
      logic signed [PRI_W-1:0] pri;
   } entry_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PREP,
      ST_SHIFT,
      ST_WRITE,
      ST_RESP
   } state_type;

endpackage

/* hdl/apq_chan_if.sv */
// Request and response channel interfaces for the array priority queue.
interface apq_req_if;
   import apq_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic signed [VAL_W-1:0] item_value;
   logic signed [PRI_W-1:0] item_priority;

   modport source (output valid, output cmd, output item_value, output item_priority,
                   input ready);
   modport sink   (input valid, input cmd, input item_value, input item_priority,
                   output ready);
endinterface

interface apq_rsp_if;
   import apq_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    ok;
   logic signed [VAL_W-1:0] out_value;
   logic signed [PRI_W-1:0] out_priority;
   logic [CNT_W-1:0]        fill_count;

   modport source (output valid, output ok, output out_value, output out_priority,
                   output fill_count, input ready);
   modport sink   (input valid, input ok, input out_value, input out_priority,
                   input fill_count, output ready);
endinterface

/* hdl/array_priority_queue_unit.sv */
// Array priority queue: entry store in one synchronous RAM with a sequencer.
//
// Usage
//   req_ch carries one command per transaction: sorted push, append push or
//   pop. rsp_ch returns exactly one transaction per command with ok, the
//   popped value and priority (zero unless a pop succeeded) and the fill
//   count after the command.
//   Entries live in a DEPTH-entry RAM (one read and one write port, registered
//   read). A sorted push reads the stored entries one per cycle to
//   find the insert slot, then moves the tail up one slot per cycle and
//   writes the new entry. A pop reads all entries to find the earliest one of
//   highest priority, then moves the later entries down one slot per cycle.
//   The response sits in an output register, so a new command is taken while
//   the previous response still waits; a stalled rsp_ch holds the sequencer
//   only when the next response is ready to be loaded.
//   Synchronous reset empties the queue; RAM contents are not cleared.
module array_priority_queue_unit (
   input  logic      clock,
   input  logic      reset,
   apq_req_if.sink   req_ch,
   apq_rsp_if.source rsp_ch
);
   import apq_pkg::*;

   // Entry storage
   entry_type mem [DEPTH];

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   cmd_type                 cmd_ff, cmd_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic signed [PRI_W-1:0] pri_ff, pri_in;
   logic                    ok_ff, ok_in;
   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic [IDX_W-1:0]        best_ff, best_in;
   logic signed [VAL_W-1:0] best_val_ff, best_val_in;
   logic signed [PRI_W-1:0] best_pri_ff, best_pri_in;
   logic [CNT_W-1:0]        iss_ff, iss_in;
   logic [IDX_W-1:0]        sh_ff, sh_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic                    rd_vld_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   entry_type               rd_data_ff;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic                    rsp_ok_ff;
   logic signed [VAL_W-1:0] rsp_val_ff;
   logic signed [PRI_W-1:0] rsp_pri_ff;
   logic [CNT_W-1:0]        rsp_fill_ff;

   logic             req_acc;
   logic             rsp_load;
   logic             is_pop;
   logic             scan_last;
   logic [CNT_W-1:0] moves;
   logic             mem_re, mem_we;
   logic [IDX_W-1:0] mem_ra, mem_wa;
   entry_type        mem_wd;

   // Handshakes
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_load     = (state_ff == ST_RESP) && (!rsp_vld_ff || rsp_ch.ready);

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.ok           = rsp_ok_ff;
   assign rsp_ch.out_value    = rsp_val_ff;
   assign rsp_ch.out_priority = rsp_pri_ff;
   assign rsp_ch.fill_count   = rsp_fill_ff;

   // Decode helpers
   assign is_pop    = (cmd_ff == CMD_POP);
   assign scan_last = rd_vld_ff && (CNT_W'(rd_idx_ff) == count_ff - CNT_W'(1));
   assign moves     = is_pop ? (count_ff - CNT_W'(best_ff) - CNT_W'(1))
                             : (count_ff - CNT_W'(pos_ff));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if ((req_ch.cmd == CMD_PUSH_SORTED || req_ch.cmd == CMD_PUSH_APPEND)
                   && count_ff < CNT_W'(DEPTH)) begin
                  if (req_ch.cmd == CMD_PUSH_SORTED && count_ff != '0) begin
                     state_in = ST_SCAN;
                  end else begin
                     state_in = ST_WRITE;
                  end
               end else if (req_ch.cmd == CMD_POP && count_ff != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (moves != '0) begin
               state_in = ST_SHIFT;
            end else begin
               state_in = is_pop ? ST_RESP : ST_WRITE;
            end
         end
         ST_SHIFT: begin
            if (left_ff == '0 && !rd_vld_ff) begin
               state_in = is_pop ? ST_RESP : ST_WRITE;
            end
         end
         ST_WRITE: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // RAM port control
   always_comb begin
      mem_re = 1'b0;
      mem_ra = '0;
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = rd_data_ff;
      unique case (state_ff)
         ST_SCAN: begin
            mem_re = (iss_ff < count_ff);
            mem_ra = iss_ff[IDX_W-1:0];
         end
         ST_SHIFT: begin
            mem_re = (left_ff != '0);
            mem_ra = sh_ff;
            mem_we = rd_vld_ff;
            mem_wa = is_pop ? (rd_idx_ff - IDX_W'(1)) : (rd_idx_ff + IDX_W'(1));
         end
         ST_WRITE: begin
            mem_we     = 1'b1;
            mem_wa     = pos_ff;
            mem_wd.val = val_ff;
            mem_wd.pri = pri_ff;
         end
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      count_in    = count_ff;
      cmd_in      = cmd_ff;
      val_in      = val_ff;
      pri_in      = pri_ff;
      ok_in       = ok_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;
      best_in     = best_ff;
      best_val_in = best_val_ff;
      best_pri_in = best_pri_ff;
      iss_in      = iss_ff;
      sh_in       = sh_ff;
      left_in     = left_ff;
      rsp_vld_in  = rsp_vld_ff;

      // capture command and decide whether it can succeed
      if (req_acc) begin
         cmd_in   = req_ch.cmd;
         val_in   = req_ch.item_value;
         pri_in   = req_ch.item_priority;
         ok_in    = ((req_ch.cmd == CMD_PUSH_SORTED || req_ch.cmd == CMD_PUSH_APPEND)
                     && count_ff < CNT_W'(DEPTH))
                    || (req_ch.cmd == CMD_POP && count_ff != '0);
         found_in = 1'b0;
         pos_in   = count_ff[IDX_W-1:0];
         iss_in   = '0;
      end

      // scan: issue reads, evaluate returning entries
      if (state_ff == ST_SCAN) begin
         if (mem_re) begin
            iss_in = iss_ff + CNT_W'(1);
         end
         if (rd_vld_ff) begin
            if (is_pop) begin
               if (rd_idx_ff == '0 || best_pri_ff < rd_data_ff.pri) begin
                  best_in     = rd_idx_ff;
                  best_val_in = rd_data_ff.val;
                  best_pri_in = rd_data_ff.pri;
               end
            end else if (!found_ff && rd_data_ff.pri < pri_ff) begin
               found_in = 1'b1;
               pos_in   = rd_idx_ff;
            end
         end
      end

      // set up the shift pass
      if (state_ff == ST_PREP) begin
         left_in = moves;
         sh_in   = is_pop ? (best_ff + IDX_W'(1)) : IDX_W'(count_ff - CNT_W'(1));
      end

      // shift: walk the source pointer
      if (state_ff == ST_SHIFT && mem_re) begin
         left_in = left_ff - CNT_W'(1);
         sh_in   = is_pop ? (sh_ff + IDX_W'(1)) : (sh_ff - IDX_W'(1));
      end

      // response register and count update
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
         if (ok_ff) begin
            count_in = is_pop ? (count_ff - CNT_W'(1)) : (count_ff + CNT_W'(1));
         end
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_vld_ff  <= mem_re;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      pri_ff      <= pri_in;
      ok_ff       <= ok_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      best_ff     <= best_in;
      best_val_ff <= best_val_in;
      best_pri_ff <= best_pri_in;
      iss_ff      <= iss_in;
      sh_ff       <= sh_in;
      left_ff     <= left_in;
      rd_idx_ff   <= mem_ra;
      if (rsp_load) begin
         rsp_ok_ff   <= ok_ff;
         rsp_val_ff  <= (ok_ff && is_pop) ? best_val_ff : '0;
         rsp_pri_ff  <= (ok_ff && is_pop) ? best_pri_ff : '0;
         rsp_fill_ff <= count_in;
      end
   end

   // Entry RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CNT_W'(mem_wa) <= count_ff))
      else $error("RAM write beyond the stored region");

   a_shift_writeback: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && rd_vld_ff) |-> mem_we)
      else $error("shifted entry not written back");

   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!mem_re && !rd_vld_ff))
      else $error("RAM read outstanding while idle");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_load |=> $stable(count_ff))
      else $error("entry count changed outside response load");

endmodule

/* verif/array_priority_queue_unit_test.sv */
// Self-checking testbench for the array priority queue unit.
module array_priority_queue_unit_test;
   import apq_pkg::*;

   // Command code the block does not define
   localparam cmd_type CMD_UNDEFINED = 2'd3;

   // Response fields as the block should report them
   typedef struct packed {
      logic                    ok;
      logic signed [VAL_W-1:0] value;
      logic signed [PRI_W-1:0] prio;
      logic [CNT_W-1:0]        fill;
   } queue_result_type;

   logic clock;
   logic reset;

   apq_req_if req_ch ();
   apq_rsp_if rsp_ch ();

   array_priority_queue_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the entry store
   logic signed [VAL_W-1:0] held_values [DEPTH];
   logic signed [PRI_W-1:0] held_prios  [DEPTH];
   int                      held_count;

   queue_result_type pending_results [$];

   int  error_count;
   int  results_checked;
   int  sorted_pushes;
   int  append_pushes;
   int  pops_done;
   int  full_refusals;
   int  empty_refusals;
   int  undefined_cmds;
   int  peak_fill;
   bit  idle_on;
   bit  stall_on;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   // Idle length: mostly none, some short, a few long
   function automatic int pick_idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Predict one command against the shadow store
   function automatic queue_result_type apply_queue_command(cmd_type cmd,
                                                         logic signed [VAL_W-1:0] val,
                                                         logic signed [PRI_W-1:0] pri);
      queue_result_type r;
      int               slot;
      int               best;
      r = '0;
      case (cmd)
         CMD_PUSH_SORTED, CMD_PUSH_APPEND: begin
            if (held_count < DEPTH) begin
               slot = held_count;
               // insert before first strictly lower priority; ties keep arrival order
               if (cmd == CMD_PUSH_SORTED) begin
                  for (int i = 0; i < held_count; i++)
                     if (slot == held_count && held_prios[i] < pri) slot = i;
               end
               for (int i = held_count; i > slot; i--) begin
                  held_values[i] = held_values[i-1];
                  held_prios[i]  = held_prios[i-1];
               end
               held_values[slot] = val;
               held_prios[slot]  = pri;
               held_count++;
               r.ok = 1'b1;
            end
         end
         CMD_POP: begin
            if (held_count > 0) begin
               // earliest entry of highest priority
               best = 0;
               for (int i = 1; i < held_count; i++)
                  if (held_prios[best] < held_prios[i]) best = i;
               r.value = held_values[best];
               r.prio  = held_prios[best];
               for (int i = best + 1; i < held_count; i++) begin
                  held_values[i-1] = held_values[i];
                  held_prios[i-1]  = held_prios[i];
               end
               held_count--;
               r.ok = 1'b1;
            end
         end
         default: ;
      endcase
      r.fill = CNT_W'(held_count);
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
      $display("MISMATCH at response %0d, %s: expected 0x%0h, got 0x%0h",
               results_checked, field, want, got);
      error_count++;
   endtask

   // Send one command transaction and record its predicted response
   task automatic send_command(cmd_type cmd, logic signed [VAL_W-1:0] val,
                               logic signed [PRI_W-1:0] pri);
      int               gap;
      queue_result_type r;
      gap = idle_on ? pick_idle_length() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.cmd           <= cmd;
      req_ch.item_value    <= val;
      req_ch.item_priority <= pri;
      do @(posedge clock); while (!req_ch.ready);
      r = apply_queue_command(cmd, val, pri);
      pending_results.push_back(r);
      // bookkeeping for the summary
      case (cmd)
         CMD_PUSH_SORTED: if (r.ok) sorted_pushes++; else full_refusals++;
         CMD_PUSH_APPEND: if (r.ok) append_pushes++; else full_refusals++;
         CMD_POP:         if (r.ok) pops_done++; else empty_refusals++;
         default:         undefined_cmds++;
      endcase
      if (held_count > peak_fill) peak_fill = held_count;
   endtask

   // Hold the sender until every outstanding response is back
   task automatic wait_all_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Priority mix: frequent ties, full range, and the extremes
   function automatic logic signed [PRI_W-1:0] random_priority();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return PRI_W'($signed($urandom_range(0, 4)) - 2);
      if (r < 8) return PRI_W'($urandom);
      case ($urandom_range(0, 3))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'shFFFF;
         default: return 16'sh0000;
      endcase
   endfunction

   // One random command; push_pct sets how hard the queue is filled
   task automatic send_random_command(int push_pct);
      int      r;
      cmd_type cmd;
      r = $urandom_range(0, 99);
      if (r < 2)
         cmd = CMD_UNDEFINED;
      else if (r < push_pct)
         cmd = ($urandom_range(0, 3) == 0) ? CMD_PUSH_APPEND : CMD_PUSH_SORTED;
      else
         cmd = CMD_POP;
      send_command(cmd, VAL_W'($urandom), random_priority());
   endtask

   // Response side stalls
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            stall_left = stall_on ? pick_idle_length() : 0;
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Response checker
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("transaction with no command outstanding", '0, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.ok !== want.ok)
               report_mismatch("ok", want.ok, rsp_ch.ok);
            if (rsp_ch.out_value !== want.value)
               report_mismatch("out_value", want.value, rsp_ch.out_value);
            if (rsp_ch.out_priority !== want.prio)
               report_mismatch("out_priority", want.prio, rsp_ch.out_priority);
            if (rsp_ch.fill_count !== want.fill)
               report_mismatch("fill_count", want.fill, rsp_ch.fill_count);
         end
         results_checked++;
      end
   end

   // Field extremes, each command, ties, empty pop and the undefined code
   task automatic test_directed_commands();
      send_command(CMD_POP, 32'sd0, 16'sd0);
      send_command(CMD_UNDEFINED, 32'sh1234_5678, 16'sh0F0F);
      send_command(CMD_PUSH_SORTED, 32'sh7FFF_FFFF, 16'sh7FFF);
      send_command(CMD_PUSH_SORTED, 32'sh8000_0000, 16'sh8000);
      send_command(CMD_PUSH_SORTED, 32'sh0000_0000, 16'sh0000);
      send_command(CMD_PUSH_SORTED, 32'shFFFF_FFFF, 16'sh0000);
      send_command(CMD_PUSH_SORTED, 32'sh0000_0011, 16'sh0000);
      // appended top priority lands behind the earlier one of the same priority
      send_command(CMD_PUSH_APPEND, 32'sh0000_0005, 16'sh7FFF);
      send_command(CMD_PUSH_APPEND, 32'shA5A5_5A5A, 16'shFFFF);
      send_command(CMD_PUSH_APPEND, 32'sh5A5A_A5A5, 16'sh7FFE);
      send_command(CMD_UNDEFINED, 32'shFFFF_FFFF, 16'shFFFF);
      repeat (9) send_command(CMD_POP, 32'shFFFF_FFFF, 16'shFFFF);
      send_command(CMD_POP, 32'sd0, 16'sd0);
   endtask

   // Fill past capacity, then drain past empty
   task automatic test_capacity_edges(int rounds);
      for (int k = 0; k < rounds; k++) begin
         repeat (DEPTH + 2)
            send_command($urandom_range(0, 1) ? CMD_PUSH_SORTED : CMD_PUSH_APPEND,
                         VAL_W'($urandom), random_priority());
         repeat (DEPTH + 1) send_command(CMD_POP, VAL_W'($urandom), PRI_W'($urandom));
      end
   endtask

   // Random traffic with shifting fill bias and occasional waits for all outstanding responses
   task automatic test_random_traffic(int count);
      int push_pct;
      push_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 75;
               1:       push_pct = 52;
               default: push_pct = 30;
            endcase
         end
         if (i % 350 == 349) wait_all_results();
         send_random_command(push_pct);
      end
   endtask

   // No gaps on either side
   task automatic test_back_to_back(int count);
      idle_on  = 1'b0;
      stall_on = 1'b0;
      for (int i = 0; i < count; i++) send_random_command(i < count / 2 ? 70 : 35);
      idle_on  = 1'b1;
      stall_on = 1'b1;
   endtask

   // Sequence of tests
   initial begin
      error_count     = 0;
      results_checked = 0;
      sorted_pushes   = 0;
      append_pushes   = 0;
      pops_done       = 0;
      full_refusals   = 0;
      empty_refusals  = 0;
      undefined_cmds  = 0;
      peak_fill       = 0;
      held_count      = 0;
      idle_on         = 1'b1;
      stall_on        = 1'b1;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.cmd           <= CMD_PUSH_SORTED;
      req_ch.item_value    <= '0;
      req_ch.item_priority <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_commands();
      test_capacity_edges(3);
      wait_all_results();
      test_random_traffic(1400);
      test_back_to_back(200);
      wait_all_results();
      repeat (2 * DEPTH + 10) @(posedge clock);

      $display("Covered %0d sorted pushes, %0d append pushes, %0d pops, %0d undefined commands",
               sorted_pushes, append_pushes, pops_done, undefined_cmds);
      $display("Peak fill %0d of %0d; %0d pushes refused when full, %0d pops refused when empty",
               peak_fill, DEPTH, full_refusals, empty_refusals);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
